[design/matrix_key_scan_debounce_assert.svh]
// assertion macros for the keypad scanner checker
`ifndef MATRIX_KEY_SCAN_DEBOUNCE_ASSERT_SVH
`define MATRIX_KEY_SCAN_DEBOUNCE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MKSD_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define MKSD_ASSERT_NEXT(name, clk, rstn, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) \
        else $error(msg);

`endif

[design/mksd_pkg.sv]
// shared widths, register codes and controller/datapath bundles
package mksd_pkg;

    localparam int IDX_W      = 6;
    localparam int ROWS_W     = 16;
    localparam int TIME_W     = 32;
    localparam int LINE_W     = 5;
    localparam int DBN_W      = 16;
    localparam int COL_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_BITS   = 2;
    localparam int DIV_CYCLES = IDX_W / DIV_BITS;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 2'd2;

    localparam logic [LINE_W-1:0] COLUMN_COUNT_RST = 5'd8;
    localparam logic [LINE_W-1:0] ROW_COUNT_RST    = 5'd8;
    localparam logic [DBN_W-1:0]  DEBOUNCE_MS_RST  = 16'd20;

    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic bad_in;
        logic div_last;
    } t_sts;

endpackage

[design/matrix_key_scan_debounce.sv]
// keypad matrix scanner with per-key debounce: top level
// sequence: an in-range beat is accepted, divided by the column count at 2 quotient bits per
//   divider cycle, then written to the table; a bad index skips the divider; the input stalls
//   until the table update, and the next beat is taken while a result waits
// reset (sync, active low): config back to 8 columns, 8 rows, 20 ms; every key reads as
//   low with time zero through cleared per-key valid bits, no clearing pass
module matrix_key_scan_debounce #(
    parameter int MAX_ELEMENTS = 64,
    parameter int MAX_LINES    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [mksd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mksd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input beat
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mksd_pkg::IDX_W-1:0]      i_element_index,
    input  logic [mksd_pkg::ROWS_W-1:0]     i_row_levels,
    input  logic [mksd_pkg::TIME_W-1:0]     i_now_ms,
    // result beat
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mksd_pkg::COL_W-1:0]      o_column_drive,
    output logic                            o_stable_level,
    output logic                            o_bad_index
);

    // control bundle to the datapath and status back
    mksd_pkg::t_cmd cmd;
    mksd_pkg::t_sts sts;

    // sequencer: idle -> divide -> update, or idle -> update for a bad index
    mksd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // per-key state table, column/row split and debounce compare
    mksd_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_LINES    (MAX_LINES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_element_index (i_element_index),
        .i_row_levels    (i_row_levels),
        .i_now_ms        (i_now_ms),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_column_drive  (o_column_drive),
        .o_stable_level  (o_stable_level),
        .o_bad_index     (o_bad_index)
    );

endmodule

[design/mksd_ctrl.sv]
// controller: sequences accept, division, table update and output beat
module mksd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  mksd_pkg::t_sts i_sts,
    output mksd_pkg::t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.bad_in ? ST_UPD : ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[design/mksd_div.sv]
// iterative restoring divider, DIV_BITS quotient bits per step
module mksd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_step,
    input  logic [mksd_pkg::IDX_W-1:0]  i_dividend,
    input  logic [mksd_pkg::LINE_W-1:0] i_divisor,
    output logic [mksd_pkg::IDX_W-1:0]  o_quo,
    output logic [mksd_pkg::LINE_W-1:0] o_rem,
    output logic                        o_last
);

    logic [mksd_pkg::IDX_W-1:0]     r_quo;
    logic [mksd_pkg::IDX_W-1:0]     n_quo;
    logic [mksd_pkg::LINE_W-1:0]    r_rem;
    logic [mksd_pkg::LINE_W-1:0]    n_rem;
    logic [mksd_pkg::DIV_CNT_W-1:0] r_cnt;

    always_comb begin
        logic [mksd_pkg::LINE_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < mksd_pkg::DIV_BITS; k++) begin
            trial = {n_rem, n_quo[mksd_pkg::IDX_W-1]};
            n_quo = {n_quo[mksd_pkg::IDX_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                trial    = trial - {1'b0, i_divisor};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[mksd_pkg::LINE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_last = (r_cnt == mksd_pkg::DIV_CNT_W'(mksd_pkg::DIV_CYCLES - 1));
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[design/mksd_dp.sv]
// datapath: config registers, key state table, divider and result register
module mksd_dp #(
    parameter int MAX_ELEMENTS = 64,
    parameter int MAX_LINES    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mksd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mksd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [mksd_pkg::IDX_W-1:0]      i_element_index,
    input  logic [mksd_pkg::ROWS_W-1:0]     i_row_levels,
    input  logic [mksd_pkg::TIME_W-1:0]     i_now_ms,
    input  mksd_pkg::t_cmd                  i_cmd,
    output mksd_pkg::t_sts                  o_sts,
    output logic [mksd_pkg::COL_W-1:0]      o_column_drive,
    output logic                            o_stable_level,
    output logic                            o_bad_index
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    typedef struct packed {
        logic [mksd_pkg::TIME_W-1:0] change_time;
        logic                        last_raw;
        logic                        settled;
    } t_entry;

    logic [mksd_pkg::LINE_W-1:0] r_col_count;
    logic [mksd_pkg::LINE_W-1:0] r_row_count;
    logic [mksd_pkg::DBN_W-1:0]  r_debounce;

    logic [mksd_pkg::LINE_W-1:0] cols_c;
    logic [mksd_pkg::LINE_W-1:0] rows_c;
    logic [2*mksd_pkg::LINE_W-1:0] count;
    logic [8:0]                  idx_ext_in;
    logic [8:0]                  idx_ext_q;
    logic [AW-1:0]               addr_in;
    logic [AW-1:0]               addr_q;

    t_entry                      mem [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]     r_valid;
    t_entry                      r_rd;
    logic                        r_rd_ok;

    logic [mksd_pkg::IDX_W-1:0]  r_idx;
    logic [mksd_pkg::ROWS_W-1:0] r_rows_lvl;
    logic [mksd_pkg::TIME_W-1:0] r_now;
    logic                        r_bad;
    logic [mksd_pkg::COL_W-1:0]  r_drv_col;

    logic [mksd_pkg::IDX_W-1:0]  quo;
    logic [mksd_pkg::LINE_W-1:0] rem;
    logic                        div_last;

    t_entry                      ent;
    t_entry                      ent_new;
    logic                        raw;
    logic [mksd_pkg::TIME_W-1:0] elapsed;
    logic                        held_long;
    logic [mksd_pkg::COL_W-1:0]  col;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= mksd_pkg::COLUMN_COUNT_RST;
            r_row_count <= mksd_pkg::ROW_COUNT_RST;
            r_debounce  <= mksd_pkg::DEBOUNCE_MS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mksd_pkg::CFG_COLUMN_COUNT: r_col_count <= i_cfg_data[mksd_pkg::LINE_W-1:0];
                mksd_pkg::CFG_ROW_COUNT:    r_row_count <= i_cfg_data[mksd_pkg::LINE_W-1:0];
                mksd_pkg::CFG_DEBOUNCE_MS:  r_debounce  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // counts saturated to line limit, index range check at accept
    assign cols_c = (6'(r_col_count) > 6'(MAX_LINES)) ? mksd_pkg::LINE_W'(MAX_LINES)
                                                      : r_col_count;
    assign rows_c = (6'(r_row_count) > 6'(MAX_LINES)) ? mksd_pkg::LINE_W'(MAX_LINES)
                                                      : r_row_count;
    assign count  = (2*mksd_pkg::LINE_W)'(cols_c) * (2*mksd_pkg::LINE_W)'(rows_c);

    assign idx_ext_in = 9'(i_element_index);
    assign idx_ext_q  = 9'(r_idx);
    assign addr_in    = idx_ext_in[AW-1:0];
    assign addr_q     = idx_ext_q[AW-1:0];

    assign o_sts.bad_in = ((2*mksd_pkg::LINE_W)'(i_element_index) >= count)
                       || (idx_ext_in >= 9'(MAX_ELEMENTS));
    assign o_sts.div_last = div_last;

    mksd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load),
        .i_step     (i_cmd.div_step),
        .i_dividend (i_element_index),
        .i_divisor  (cols_c),
        .o_quo      (quo),
        .o_rem      (rem),
        .o_last     (div_last)
    );

    // capture of the beat and table read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx      <= i_element_index;
            r_rows_lvl <= i_row_levels;
            r_now      <= i_now_ms;
            r_bad      <= o_sts.bad_in;
            r_rd       <= mem[addr_in];
            r_rd_ok    <= r_valid[addr_in];
        end
    end

    // debounce update
    always_comb begin
        ent       = r_rd_ok ? r_rd : '0;
        raw       = (quo[mksd_pkg::IDX_W-1:4] == '0) ? r_rows_lvl[quo[3:0]] : 1'b0;
        elapsed   = r_now - ent.change_time;
        held_long = elapsed >= mksd_pkg::TIME_W'(r_debounce);
        ent_new.last_raw    = raw;
        ent_new.change_time = (raw == ent.last_raw) ? ent.change_time : r_now;
        ent_new.settled     = ((raw == ent.last_raw) && held_long) ? raw : ent.settled;
        col = rem[mksd_pkg::COL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_bad) begin
            mem[addr_q] <= ent_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_drv_col <= '0;
        end else if (i_cmd.commit && !r_bad) begin
            r_valid[addr_q] <= 1'b1;
            r_drv_col       <= col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_column_drive <= r_bad ? r_drv_col : col;
            o_stable_level <= r_bad ? 1'b0 : ent_new.settled;
            o_bad_index    <= r_bad;
        end
    end

endmodule

[design/mksd_checker.sv]
// port-level checker for the keypad scanner, bound to the top level
`include "matrix_key_scan_debounce_assert.svh"

module mksd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [mksd_pkg::COL_W-1:0] o_column_drive,
    input logic                       o_stable_level,
    input logic                       o_bad_index
);

    logic in_beat;

    assign in_beat = i_in_valid && !o_in_stall;

    `MKSD_ASSERT(a_bad_reads_low, i_clk, i_rst_n, !(o_out_valid && o_bad_index && o_stable_level), "bad index result with stable level high")
    `MKSD_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, o_in_stall, "input not stalled after a beat")
    `MKSD_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_beat, !$rose(o_out_valid), "result beat one cycle after input beat")
    `MKSD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_column_drive) && $stable(o_stable_level) && $stable(o_bad_index), "stalled result changed")

endmodule

bind matrix_key_scan_debounce mksd_checker u_mksd_checker (.*);
